FILE: rtl/ccu_pkg.sv
// Shared constants, result type and calendar tables for the calendar clock / Unix converter.
package ccu_pkg;

  // Calendar span covered by the year offset field (years from 2000)
  localparam int YEAR_SPAN = 64;

  // Register stages from an accepted beat to the datapath results
  localparam int PIPE_LAT = 9;

  // Day numbers (days since 1970-01-01) bounding the calendar
  localparam logic [15:0] EPOCH_DAYS = 16'd10957;
  localparam logic [15:0] LAST_DAYS  =
    16'(10957 + YEAR_SPAN * 365 + (YEAR_SPAN + 3) / 4);

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // Seconds / 86400 is done as (seconds >> 7) / 675
  localparam logic [9:0]  DAY_DIV    = 10'd675;
  localparam logic [25:0] DAY_RECIP  = 26'd50903316;   // floor(2^35 / 675)
  localparam int          DAY_SHIFT  = 35;
  localparam logic [10:0] HOUR_RECIP = 11'd1165;       // floor(2^22 / 3600)
  localparam int          HOUR_SHIFT = 22;
  localparam logic [10:0] MIN_RECIP  = 11'd1092;       // floor(2^16 / 60)
  localparam int          MIN_SHIFT  = 16;
  localparam logic [10:0] QUAD_DAYS  = 11'd1461;       // days in a four-year block
  localparam logic [15:0] QUAD_RECIP = 16'd45933;      // floor(2^26 / 1461)
  localparam int          QUAD_SHIFT = 26;

  // One converted result plus its convertible flag
  typedef struct packed {
    logic        ok;
    logic [31:0] data;
  } ccu_res_t;

  // Days in the year before the first of month mon (1..12)
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    month_start = base + ((leap && (mon > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

  // Length of month mon (1..12); zero for codes that are not months
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      4'd2:                                         len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:   len = 5'd31;
      default:                                      len = 5'd0;
    endcase
    month_len = len;
  endfunction

endpackage

FILE: rtl/calendar_clock_unix_converter_top.sv
// Top level of the calendar clock / Unix seconds converter.
//
// Command channel: a beat (mode, clock_word, unix_seconds) is taken at each
// rising edge with start high and busy low. busy is low except during reset,
// so a new beat can be taken every cycle.
// mode 0 turns the packed clock word into Unix seconds; mode 1 turns Unix
// seconds into a packed clock word. Both directions run side by side in a
// nine-stage pipeline and the mode picks the result at the output register.
// Result channel: done is high for exactly one cycle per beat, set from the
// output register at the end of the pipeline, with valid_res, unix_result and clock_result.
// Results of rejected inputs, and the result field of the other direction,
// are zero. Throughput is one beat per cycle outside reset; the receiver cannot
// stall: results leave on their cycle whether taken or not.
// Reset (rst, synchronous) clears the valid bits of all stages, so beats
// in flight are dropped and done stays low until new beats emerge.
module calendar_clock_unix_converter_top import ccu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] clock_word,
  input  logic [31:0] unix_seconds,
  output logic        done,
  output logic        valid_res,
  output logic [31:0] unix_result,
  output logic [31:0] clock_result
);

  logic     vld [PIPE_LAT];
  logic     md  [PIPE_LAT];
  ccu_res_t tu_res;
  ccu_res_t fu_res;

  assign busy = rst;

  ccu_to_unix u_to_unix (
    .clk        (clk),
    .clock_word (clock_word),
    .res        (tu_res)
  );

  ccu_from_unix u_from_unix (
    .clk          (clk),
    .unix_seconds (unix_seconds),
    .res          (fu_res)
  );

  // Valid and mode travel alongside the datapath stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= start & ~busy;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    md[0] <= mode;
    for (int i = 1; i < PIPE_LAT; i++) begin
      md[i] <= md[i-1];
    end
  end

  // Output register: pick the direction and strobe the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    valid_res    <= md[PIPE_LAT-1] ? fu_res.ok : tu_res.ok;
    unix_result  <= md[PIPE_LAT-1] ? 32'd0 : tu_res.data;
    clock_result <= md[PIPE_LAT-1] ? fu_res.data : 32'd0;
  end

endmodule

FILE: rtl/ccu_to_unix.sv
// Clock word to Unix seconds pipeline: field check, day number, scale by a day, add time of day.
module ccu_to_unix import ccu_pkg::*; (
  input  logic        clk,
  input  logic [31:0] clock_word,
  output ccu_res_t    res
);

  localparam int DLY = PIPE_LAT - 2;

  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hour;
  logic [4:0]  day;
  logic [3:0]  mon;
  logic [5:0]  yoff;
  logic        leap;
  logic        ok1;
  logic [15:0] days1;
  logic [16:0] tod1;

  logic        s1_ok;
  logic [15:0] s1_days;
  logic [16:0] s1_tod;
  logic        s2_ok;
  logic [31:0] s2_prod;
  logic [16:0] s2_tod;
  ccu_res_t    dly [DLY];

  // Stage 1: unpack, range check, day number and time of day
  always_comb begin
    sec  = clock_word[5:0];
    min  = clock_word[11:6];
    hour = clock_word[16:12];
    day  = clock_word[21:17];
    mon  = clock_word[25:22];
    yoff = clock_word[31:26];
    leap = (yoff[1:0] == 2'b00);
    ok1  = ({1'b0, yoff} < 7'(YEAR_SPAN)) && (hour <= 5'd23) && (min <= 6'd59) &&
           (sec <= 6'd59) && (mon != 4'd0) && (mon <= 4'd12) && (day != 5'd0) &&
           (day <= month_len(mon, leap));
    days1 = EPOCH_DAYS + 16'(yoff) * 16'd365 + 16'((7'(yoff) + 7'd3) >> 2) +
            16'(month_start(mon, leap)) + 16'(day) - 16'd1;
    tod1  = 17'(hour) * 17'(SECS_PER_HOUR) + 17'(min) * 17'(SECS_PER_MIN) + 17'(sec);
  end

  always_ff @(posedge clk) begin
    s1_ok   <= ok1;
    s1_days <= days1;
    s1_tod  <= tod1;
  end

  // Stage 2: days to seconds
  always_ff @(posedge clk) begin
    s2_ok   <= s1_ok;
    s2_prod <= 32'(s1_days) * SECS_PER_DAY;
    s2_tod  <= s1_tod;
  end

  // Stage 3: final add, then delay to line up with the other direction
  always_ff @(posedge clk) begin
    dly[0].ok   <= s2_ok;
    dly[0].data <= s2_ok ? (s2_prod + 32'(s2_tod)) : 32'd0;
    for (int i = 1; i < DLY; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  assign res = dly[DLY-1];

endmodule

FILE: rtl/ccu_from_unix.sv
// Unix seconds to clock word pipeline: constant divisions by reciprocal and correction.
module ccu_from_unix import ccu_pkg::*; (
  input  logic        clk,
  input  logic [31:0] unix_seconds,
  output ccu_res_t    res
);

  // Stage registers
  logic [24:0] r1_x;
  logic [6:0]  r1_lo;
  logic [50:0] r1_prod;

  logic [15:0] r2_q;
  logic [10:0] r2_r;
  logic [6:0]  r2_lo;

  logic        r3_ok;
  logic [16:0] r3_sod;
  logic [14:0] r3_n;

  logic        r4_ok;
  logic [16:0] r4_sod;
  logic [14:0] r4_n;
  logic [27:0] r4_hp;
  logic [30:0] r4_np;

  logic        r5_ok;
  logic [4:0]  r5_h;
  logic [12:0] r5_rh;
  logic [4:0]  r5_q;
  logic [11:0] r5_r4;

  logic        r6_ok;
  logic [4:0]  r6_hour;
  logic [11:0] r6_rm;
  logic [5:0]  r6_yoff;
  logic [8:0]  r6_doy;
  logic        r6_leap;

  logic        r7_ok;
  logic [22:0] r7_mp;
  logic [11:0] r7_rm;
  logic [3:0]  r7_mon;
  logic [4:0]  r7_day;
  logic [4:0]  r7_hour;
  logic [5:0]  r7_yoff;

  logic        r8_ok;
  logic [5:0]  r8_min;
  logic [6:0]  r8_rs;
  logic [3:0]  r8_mon;
  logic [4:0]  r8_day;
  logic [4:0]  r8_hour;
  logic [5:0]  r8_yoff;

  // Combinational values per stage
  logic [15:0] q0;
  logic [25:0] qm;
  logic [25:0] rfull;
  logic        dover;
  logic [15:0] days;
  logic [10:0] remd;
  logic [4:0]  h0;
  logic [16:0] hm;
  logic [4:0]  q40;
  logic [14:0] qm4;
  logic        hov;
  logic        qov;
  logic [11:0] rq;
  logic [1:0]  yib;
  logic [10:0] ystart;
  logic [6:0]  yfull;
  logic [3:0]  mon7;
  logic [8:0]  mday;
  logic [5:0]  m0;
  logic [11:0] mm;
  logic        mov;

  // Stage 1: seconds / 86400 estimate
  always_ff @(posedge clk) begin
    r1_x    <= unix_seconds[31:7];
    r1_lo   <= unix_seconds[6:0];
    r1_prod <= 51'(unix_seconds[31:7]) * 51'(DAY_RECIP);
  end

  // Stage 2: day estimate and its remainder
  always_comb begin
    q0    = r1_prod[DAY_SHIFT +: 16];
    qm    = 26'(q0) * 26'(DAY_DIV);
    rfull = {1'b0, r1_x} - qm;
  end

  always_ff @(posedge clk) begin
    r2_q  <= q0;
    r2_r  <= rfull[10:0];
    r2_lo <= r1_lo;
  end

  // Stage 3: correct day number, second of day, calendar range
  always_comb begin
    dover = (r2_r >= 11'(DAY_DIV));
    days  = r2_q + 16'(dover);
    remd  = dover ? (r2_r - 11'(DAY_DIV)) : r2_r;
  end

  always_ff @(posedge clk) begin
    r3_ok  <= (days >= EPOCH_DAYS) && (days < LAST_DAYS);
    r3_sod <= {remd[9:0], r2_lo};
    r3_n   <= 15'(days - EPOCH_DAYS);
  end

  // Stage 4: hour and four-year block estimates
  always_ff @(posedge clk) begin
    r4_ok  <= r3_ok;
    r4_sod <= r3_sod;
    r4_n   <= r3_n;
    r4_hp  <= 28'(r3_sod) * 28'(HOUR_RECIP);
    r4_np  <= 31'(r3_n) * 31'(QUAD_RECIP);
  end

  // Stage 5: remainders of the estimates
  always_comb begin
    h0  = r4_hp[HOUR_SHIFT +: 5];
    hm  = 17'(h0) * 17'(SECS_PER_HOUR);
    q40 = r4_np[QUAD_SHIFT +: 5];
    qm4 = 15'(q40) * 15'(QUAD_DAYS);
  end

  always_ff @(posedge clk) begin
    r5_ok <= r4_ok;
    r5_h  <= h0;
    r5_rh <= 13'(r4_sod - hm);
    r5_q  <= q40;
    r5_r4 <= 12'(r4_n - qm4);
  end

  // Stage 6: correct hour and block, year within block, day of year
  always_comb begin
    hov = (r5_rh >= 13'(SECS_PER_HOUR));
    qov = (r5_r4 >= 12'(QUAD_DAYS));
    rq  = qov ? (r5_r4 - 12'(QUAD_DAYS)) : r5_r4;
    // first year of a block is the leap year
    if (rq < 12'd366) begin
      yib    = 2'd0;
      ystart = 11'd0;
    end else if (rq < 12'd731) begin
      yib    = 2'd1;
      ystart = 11'd366;
    end else if (rq < 12'd1096) begin
      yib    = 2'd2;
      ystart = 11'd731;
    end else begin
      yib    = 2'd3;
      ystart = 11'd1096;
    end
    yfull = {5'(r5_q + 5'(qov)), yib};
  end

  always_ff @(posedge clk) begin
    r6_ok   <= r5_ok;
    r6_hour <= r5_h + 5'(hov);
    r6_rm   <= hov ? 12'(r5_rh - 13'(SECS_PER_HOUR)) : r5_rh[11:0];
    r6_yoff <= yfull[5:0];
    r6_doy  <= 9'(rq - 12'(ystart));
    r6_leap <= (yib == 2'd0);
  end

  // Stage 7: month and day, minute estimate
  always_comb begin
    mon7 = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (r6_doy >= month_start(4'(k), r6_leap)) mon7 = 4'(k);
    end
    mday = r6_doy - month_start(mon7, r6_leap) + 9'd1;
  end

  always_ff @(posedge clk) begin
    r7_ok   <= r6_ok;
    r7_mp   <= 23'(r6_rm) * 23'(MIN_RECIP);
    r7_rm   <= r6_rm;
    r7_mon  <= mon7;
    r7_day  <= mday[4:0];
    r7_hour <= r6_hour;
    r7_yoff <= r6_yoff;
  end

  // Stage 8: minute estimate remainder
  always_comb begin
    m0 = r7_mp[MIN_SHIFT +: 6];
    mm = 12'(m0) * 12'(SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    r8_ok   <= r7_ok;
    r8_min  <= m0;
    r8_rs   <= 7'(r7_rm - mm);
    r8_mon  <= r7_mon;
    r8_day  <= r7_day;
    r8_hour <= r7_hour;
    r8_yoff <= r7_yoff;
  end

  // Stage 9: correct minute and second, pack the clock word
  assign mov = (r8_rs >= 7'(SECS_PER_MIN));

  always_ff @(posedge clk) begin
    res.ok   <= r8_ok;
    res.data <= r8_ok ? {r8_yoff, r8_mon, r8_day, r8_hour, 6'(r8_min + 6'(mov)),
                         mov ? 6'(r8_rs - 7'(SECS_PER_MIN)) : r8_rs[5:0]} : 32'd0;
  end

endmodule
